@@ hdl/gmpd_pkg.sv @@
// Shared types, constants and state encoding for the Gaussian mixture density block.
// Used by gmpd_cell, gmpd_hstep and the top level; depends on nothing.
package gmpd_pkg;

    localparam int unsigned MAX_COMPONENTS = 16;
    localparam int unsigned CHANNELS       = 3;
    localparam int unsigned HORNER_STEPS   = 10;

    localparam logic [28:0] INV_NORM   = 29'd272703090;
    localparam logic [31:0] HALF_LOG2E = 32'd3098164009;
    localparam logic [31:0] LN2        = 32'd2977044472;

    localparam logic CMD_ADD  = 1'b0;
    localparam logic CMD_EVAL = 1'b1;

    typedef struct packed {
        logic [2:0][15:0] mean;
        logic [2:0][31:0] inv;
        logic [31:0]      coef;
    } t_comp;

    typedef struct packed {
        logic        vld;
        logic [6:0]  n;
        logic [31:0] coef;
        logic [31:0] t;
    } t_lane;

    typedef enum logic [3:0] {
        S_IDLE, S_CHECK, S_INVGO, S_INVW, S_SQGO, S_SQW,
        S_CFGO, S_CFW, S_STORE, S_EVAL, S_DRAIN, S_DONE
    } t_state;

endpackage

@@ hdl/gmpd_cell.sv @@
// One component cell of the rotating component chain.
// Depends on gmpd_pkg for the component record.
module gmpd_cell (
    input  logic           i_clk,
    input  logic           i_load,
    input  gmpd_pkg::t_comp i_load_data,
    input  logic           i_shift,
    input  gmpd_pkg::t_comp i_next,
    output gmpd_pkg::t_comp o_data
);
    gmpd_pkg::t_comp r_data;

    always_ff @(posedge i_clk) begin
        if (i_shift) begin
            r_data <= i_next;
        end else if (i_load) begin
            r_data <= i_load_data;
        end
    end

    assign o_data = r_data;
endmodule

@@ hdl/gmpd_div.sv @@
// Restoring 64 by 64 bit divider, one quotient bit per cycle.
// Standalone; used by the top level for reciprocals and coefficients.
module gmpd_div (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [63:0] i_num,
    input  logic [63:0] i_den,
    output logic        o_done,
    output logic [63:0] o_quot
);
    logic        r_busy;
    logic [5:0]  r_cnt;
    logic [63:0] r_num;
    logic [63:0] r_den;
    logic [64:0] r_rem;
    logic [63:0] r_quot;
    logic [64:0] n_rem;
    logic        n_bit;

    always_comb begin
        n_rem = {r_rem[63:0], r_num[63]};
        n_bit = (n_rem >= {1'b0, r_den});
        if (n_bit) begin
            n_rem = n_rem - {1'b0, r_den};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_cnt  <= '0;
        end else if (r_busy) begin
            r_cnt <= r_cnt + 6'd1;
            if (r_cnt == 6'd63) begin
                r_busy <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_num  <= i_num;
            r_den  <= i_den;
            r_rem  <= '0;
            r_quot <= '0;
        end else if (r_busy) begin
            r_num  <= {r_num[62:0], 1'b0};
            r_rem  <= n_rem;
            r_quot <= {r_quot[62:0], n_bit};
        end
    end

    assign o_done = r_busy && (r_cnt == 6'd63);
    assign o_quot = {r_quot[62:0], n_bit};
endmodule

@@ hdl/gmpd_isqrt.sv @@
// Digit-by-digit integer square root of a 64-bit value, two bits per cycle.
// Standalone; used by the top level for the normalization product.
module gmpd_isqrt (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [63:0] i_val,
    output logic        o_done,
    output logic [31:0] o_root
);
    logic        r_busy;
    logic [63:0] r_v;
    logic [63:0] r_r;
    logic [63:0] r_b;
    logic [63:0] n_v;
    logic [63:0] n_r;
    logic [63:0] w_sum;

    always_comb begin
        w_sum = r_r + r_b;
        n_v   = r_v;
        n_r   = r_r >> 1;
        if (r_v >= w_sum) begin
            n_v = r_v - w_sum;
            n_r = (r_r >> 1) + r_b;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
        end else if (i_start) begin
            r_busy <= 1'b1;
        end else if (r_busy && r_b == 64'd1) begin
            r_busy <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_v <= i_val;
            r_r <= '0;
            r_b <= 64'd1 << 62;
        end else if (r_busy) begin
            r_v <= n_v;
            r_r <= n_r;
            r_b <= r_b >> 2;
        end
    end

    assign o_done = r_busy && (r_b == 64'd1);
    assign o_root = n_r[31:0];
endmodule

@@ hdl/gmpd_hstep.sv @@
// One Horner step of the exponential series: r <= 1 - t*r/K, t in Q0.32, r in Q1.32, three stages.
// Depends on gmpd_pkg for the lane record.
module gmpd_hstep #(
    parameter int unsigned K = 1
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  gmpd_pkg::t_lane i_lane,
    input  logic [32:0]     i_r,
    output gmpd_pkg::t_lane o_lane,
    output logic [32:0]     o_r
);
    localparam logic [35:0] RECIP = 36'((64'd1 << 35) / K);
    localparam logic [35:0] KW    = 36'(K);

    gmpd_pkg::t_lane r_lane1, r_lane2, r_lane3;
    logic [31:0] r_p1, r_p2, r_q2;
    logic [32:0] r_r3;
    logic [64:0] w_tr;
    logic [67:0] w_pq;
    logic [35:0] w_rem;
    logic [31:0] w_q;

    assign w_tr  = 65'(i_lane.t) * 65'(i_r);
    assign w_pq  = 68'(r_p1) * 68'(RECIP);
    assign w_rem = 36'(r_p2) - 36'(r_q2) * KW;
    assign w_q   = (w_rem >= KW) ? r_q2 + 32'd1 : r_q2;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lane1 <= '0;
            r_lane2 <= '0;
            r_lane3 <= '0;
        end else begin
            r_lane1 <= i_lane;
            r_lane2 <= r_lane1;
            r_lane3 <= r_lane2;
        end
    end

    always_ff @(posedge i_clk) begin
        r_p1 <= w_tr[63:32];
        r_p2 <= r_p1;
        r_q2 <= w_pq[66:35];
        r_r3 <= 33'h1_0000_0000 - 33'(w_q);
    end

    assign o_lane = r_lane3;
    assign o_r    = r_r3;
endmodule

@@ hdl/gaussian_mixture_pixel_density.sv @@
// Gaussian mixture pixel density: top level with control, component chain and datapath.
// Evaluate rotates the component chain once into the exp pipeline, then drains the pipeline;
// add runs the divider and the square root once per channel, then the divider for the coefficient.
// One word is in work at a time; input is taken again once the result sits in the output register.
// Reset (synchronous, active low) empties the store and drops any pending output word.
module gaussian_mixture_pixel_density #(
    parameter int unsigned MAX_COMPONENTS = gmpd_pkg::MAX_COMPONENTS,
    parameter int unsigned CHANNELS       = gmpd_pkg::CHANNELS
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_s_axis_tvalid,
    output logic         o_s_axis_tready,
    // mean r,g,b (16 each), variance r,g,b (24 each), weight (17), pixel r,g,b (8 each)
    input  logic [167:0] i_s_axis_tdata,
    // command
    input  logic         i_s_axis_tuser,
    output logic         o_m_axis_tvalid,
    input  logic         i_m_axis_tready,
    // density (32), accepted (1), saturated (1)
    output logic [39:0]  o_m_axis_tdata
);
    localparam int unsigned USED      = (CHANNELS < 3) ? CHANNELS : 3;
    localparam int unsigned CW        = $clog2(MAX_COMPONENTS + 1);
    localparam int unsigned IDXW      = (MAX_COMPONENTS > 1) ? $clog2(MAX_COMPONENTS) : 1;
    localparam int unsigned NSHIFT    = 12 * (3 - USED);
    localparam logic [5:0]  DRAIN_LEN = 6'd44;

    gmpd_pkg::t_state r_state, n_state;

    logic [CW-1:0]    r_count;
    logic [IDXW-1:0]  r_idx;
    logic [5:0]       r_cnt;
    logic [1:0]       r_ch;
    logic             r_m_valid;
    logic [39:0]      r_m_data;

    logic             r_cmd;
    logic [2:0][15:0] r_mean;
    logic [2:0][23:0] r_var;
    logic [16:0]      r_w;
    logic [2:0][7:0]  r_pix;
    logic [2:0][31:0] r_inv;
    logic [59:0]      r_d;
    logic [31:0]      r_coef;
    logic             r_acc;
    logic [47:0]      r_sum;

    logic             w_take, w_ok, w_last_ch;
    logic             w_div_start, w_sq_start, w_shift, w_load, w_issue, w_out_load;
    logic [63:0]      w_div_num, w_div_den, w_quot;
    logic             w_div_done, w_sq_done;
    logic [31:0]      w_root, w_quot_sat;

    gmpd_pkg::t_comp  w_cell [MAX_COMPONENTS];
    gmpd_pkg::t_comp  w_new;

    assign w_take    = i_s_axis_tvalid && o_s_axis_tready;
    assign w_last_ch = (r_ch == 2'(USED - 1));
    assign w_quot_sat = (w_quot[63:32] != '0) ? 32'hFFFF_FFFF : w_quot[31:0];

    always_comb begin
        w_ok = (r_count < CW'(MAX_COMPONENTS));
        for (int c = 0; c < USED; c++) begin
            if (r_var[c] == '0) begin
                w_ok = 1'b0;
            end
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            gmpd_pkg::S_IDLE:  if (w_take) n_state = gmpd_pkg::S_CHECK;
            gmpd_pkg::S_CHECK: begin
                if (r_cmd == gmpd_pkg::CMD_EVAL) n_state = gmpd_pkg::S_EVAL;
                else if (!w_ok) n_state = gmpd_pkg::S_DONE;
                else n_state = gmpd_pkg::S_INVGO;
            end
            gmpd_pkg::S_INVGO: n_state = gmpd_pkg::S_INVW;
            gmpd_pkg::S_INVW:  if (w_div_done) n_state = gmpd_pkg::S_SQGO;
            gmpd_pkg::S_SQGO:  n_state = gmpd_pkg::S_SQW;
            gmpd_pkg::S_SQW: begin
                if (w_sq_done) n_state = w_last_ch ? gmpd_pkg::S_CFGO : gmpd_pkg::S_INVGO;
            end
            gmpd_pkg::S_CFGO:  n_state = gmpd_pkg::S_CFW;
            gmpd_pkg::S_CFW:   if (w_div_done) n_state = gmpd_pkg::S_STORE;
            gmpd_pkg::S_STORE: n_state = gmpd_pkg::S_DONE;
            gmpd_pkg::S_EVAL: begin
                if (r_idx == IDXW'(MAX_COMPONENTS - 1)) n_state = gmpd_pkg::S_DRAIN;
            end
            gmpd_pkg::S_DRAIN: if (r_cnt == DRAIN_LEN) n_state = gmpd_pkg::S_DONE;
            gmpd_pkg::S_DONE:  if (!r_m_valid || i_m_axis_tready) n_state = gmpd_pkg::S_IDLE;
            default:           n_state = gmpd_pkg::S_IDLE;
        endcase
    end

    always_comb begin
        o_s_axis_tready = (r_state == gmpd_pkg::S_IDLE);
        w_div_start     = (r_state == gmpd_pkg::S_INVGO) || (r_state == gmpd_pkg::S_CFGO);
        w_sq_start      = (r_state == gmpd_pkg::S_SQGO);
        w_shift         = (r_state == gmpd_pkg::S_EVAL);
        w_load          = (r_state == gmpd_pkg::S_STORE);
        w_issue         = (r_state == gmpd_pkg::S_EVAL) && (CW'(r_idx) < r_count);
        w_out_load      = (r_state == gmpd_pkg::S_DONE) && (!r_m_valid || i_m_axis_tready);
        w_div_num       = 64'h1_0000_0000;
        w_div_den       = 64'(r_var[r_ch]);
        if (r_state == gmpd_pkg::S_CFGO) begin
            w_div_num = 64'(46'(r_w) * 46'(gmpd_pkg::INV_NORM)) << 12;
            w_div_den = 64'(r_d) << NSHIFT;
        end
    end

    gmpd_div u_div (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(w_div_start),
        .i_num(w_div_num), .i_den(w_div_den), .o_done(w_div_done), .o_quot(w_quot)
    );

    gmpd_isqrt u_sqrt (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(w_sq_start),
        .i_val(64'(r_var[r_ch]) << 16), .o_done(w_sq_done), .o_root(w_root)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= gmpd_pkg::S_IDLE;
            r_count   <= '0;
            r_idx     <= '0;
            r_cnt     <= '0;
            r_ch      <= '0;
            r_m_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (w_load) r_count <= r_count + CW'(1);
            if (r_state == gmpd_pkg::S_CHECK) begin
                r_idx <= '0;
                r_cnt <= '0;
                r_ch  <= '0;
            end
            if (r_state == gmpd_pkg::S_EVAL) r_idx <= r_idx + IDXW'(1);
            if (r_state == gmpd_pkg::S_DRAIN) r_cnt <= r_cnt + 6'd1;
            if (r_state == gmpd_pkg::S_SQW && w_sq_done && !w_last_ch) r_ch <= r_ch + 2'd1;
            if (w_out_load) r_m_valid <= 1'b1;
            else if (i_m_axis_tready) r_m_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_take) begin
            r_cmd  <= i_s_axis_tuser;
            r_mean <= {i_s_axis_tdata[47:32], i_s_axis_tdata[31:16], i_s_axis_tdata[15:0]};
            r_var  <= {i_s_axis_tdata[119:96], i_s_axis_tdata[95:72], i_s_axis_tdata[71:48]};
            r_w    <= i_s_axis_tdata[136:120];
            r_pix  <= {i_s_axis_tdata[160:153], i_s_axis_tdata[152:145],
                       i_s_axis_tdata[144:137]};
        end
        if (r_state == gmpd_pkg::S_CHECK) begin
            r_d   <= 60'd1;
            r_acc <= 1'b0;
            r_inv <= '0;
        end
        if (r_state == gmpd_pkg::S_INVW && w_div_done) r_inv[r_ch] <= w_quot_sat;
        if (r_state == gmpd_pkg::S_SQW && w_sq_done) r_d <= 60'(r_d[39:0] * w_root[19:0]);
        if (r_state == gmpd_pkg::S_CFW && w_div_done) r_coef <= w_quot_sat;
        if (w_load) r_acc <= 1'b1;
        if (w_out_load) begin
            if (r_cmd == gmpd_pkg::CMD_EVAL) begin
                r_m_data <= (r_sum[47:32] != '0) ? {6'd0, 1'b1, 1'b0, 32'hFFFF_FFFF}
                                                 : {6'd0, 1'b0, 1'b0, r_sum[31:0]};
            end else begin
                r_m_data <= {6'd0, 1'b0, r_acc, 32'd0};
            end
        end
    end

    assign o_m_axis_tvalid = r_m_valid;
    assign o_m_axis_tdata  = r_m_data;

    // component chain, rotated once per evaluate
    always_comb begin
        w_new = '0;
        for (int c = 0; c < USED; c++) begin
            w_new.mean[c] = r_mean[c];
            w_new.inv[c]  = r_inv[c];
        end
        w_new.coef = r_coef;
    end

    for (genvar j = 0; j < MAX_COMPONENTS; j++) begin : g_cell
        gmpd_cell u_cell (
            .i_clk(i_clk),
            .i_load(w_load && (r_count == CW'(j))),
            .i_load_data(w_new),
            .i_shift(w_shift),
            .i_next(w_cell[(j + 1) % MAX_COMPONENTS]),
            .o_data(w_cell[j])
        );
    end

    // evaluation pipeline
    logic [2:0][31:0] r_sq, r_inv0;
    logic [2:0][39:0] r_prod;
    logic [22:0]      r_m2;
    logic [22:0]      r_y3;
    logic             r_v0, r_v1, r_v2, r_v3;
    logic [31:0]      r_c0, r_c1, r_c2, r_c3;
    gmpd_pkg::t_lane  r_lane4;
    gmpd_pkg::t_lane  w_lane [gmpd_pkg::HORNER_STEPS + 1];
    logic [32:0]      w_r [gmpd_pkg::HORNER_STEPS + 1];
    logic [41:0]      w_m;
    logic [54:0]      w_y;
    logic [47:0]      w_t;
    logic [2:0][15:0] w_dist;
    logic             r_v5, r_v6;
    logic [31:0]      r_c5;
    logic [32:0]      r_e5;
    logic [40:0]      r_ct6;
    logic [64:0]      w_ce;

    always_comb begin
        for (int c = 0; c < 3; c++) begin
            if ({r_pix[c], 8'h00} >= w_cell[0].mean[c]) begin
                w_dist[c] = {r_pix[c], 8'h00} - w_cell[0].mean[c];
            end else begin
                w_dist[c] = w_cell[0].mean[c] - {r_pix[c], 8'h00};
            end
            if (c >= USED) w_dist[c] = '0;
        end
        w_m = 42'(r_prod[0]) + 42'(r_prod[1]) + 42'(r_prod[2]);
        w_y = 55'(r_m2) * 55'(gmpd_pkg::HALF_LOG2E);
        w_t = 48'(r_y3[15:0]) * 48'(gmpd_pkg::LN2);
        w_ce = 65'(r_c5) * 65'(r_e5);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v0    <= 1'b0;
            r_v1    <= 1'b0;
            r_v2    <= 1'b0;
            r_v3    <= 1'b0;
            r_lane4 <= '0;
            r_v5    <= 1'b0;
            r_v6    <= 1'b0;
        end else begin
            r_v0    <= w_issue;
            r_v1    <= r_v0;
            r_v2    <= r_v1 && (w_m[41:23] == '0);
            r_v3    <= r_v2;
            r_lane4 <= '{vld: r_v3, n: r_y3[22:16], coef: r_c3, t: w_t[47:16]};
            r_v5    <= w_lane[gmpd_pkg::HORNER_STEPS].vld;
            r_v6    <= r_v5;
        end
    end

    always_ff @(posedge i_clk) begin
        for (int c = 0; c < 3; c++) begin
            r_sq[c]   <= 32'(w_dist[c] * w_dist[c]);
            r_inv0[c] <= w_cell[0].inv[c];
            r_prod[c] <= 40'((64'(r_sq[c]) * 64'(r_inv0[c])) >> 24);
        end
        r_c0  <= w_cell[0].coef;
        r_c1  <= r_c0;
        r_c2  <= r_c1;
        r_c3  <= r_c2;
        r_m2  <= w_m[22:0];
        r_y3  <= w_y[54:32];
        r_c5  <= w_lane[gmpd_pkg::HORNER_STEPS].coef;
        r_e5  <= (w_lane[gmpd_pkg::HORNER_STEPS].n > 7'd32) ? 33'd0
               : w_r[gmpd_pkg::HORNER_STEPS] >> w_lane[gmpd_pkg::HORNER_STEPS].n[5:0];
        r_ct6 <= w_ce[64:24];
        if (r_state == gmpd_pkg::S_CHECK) r_sum <= '0;
        else if (r_v6) r_sum <= r_sum + 48'(r_ct6);
    end

    assign w_lane[0] = r_lane4;
    assign w_r[0]    = 33'h1_0000_0000;

    for (genvar k = 0; k < gmpd_pkg::HORNER_STEPS; k++) begin : g_horner
        gmpd_hstep #(.K(gmpd_pkg::HORNER_STEPS - k)) u_step (
            .i_clk(i_clk), .i_rst_n(i_rst_n),
            .i_lane(w_lane[k]), .i_r(w_r[k]),
            .o_lane(w_lane[k + 1]), .o_r(w_r[k + 1])
        );
    end
endmodule

@@ hdl/gmpd_checker.sv @@
// Port-level checks for the Gaussian mixture density block, bound to the top level.
// Depends only on the ports of gaussian_mixture_pixel_density.
module gmpd_checker (
    input logic         i_clk,
    input logic         i_rst_n,
    input logic         i_s_axis_tvalid,
    input logic         o_s_axis_tready,
    input logic [167:0] i_s_axis_tdata,
    input logic         i_s_axis_tuser,
    input logic         o_m_axis_tvalid,
    input logic         i_m_axis_tready,
    input logic [39:0]  o_m_axis_tdata
);
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !i_m_axis_tready |=> o_m_axis_tvalid && $stable(o_m_axis_tdata))
        else $error("output word changed while stalled");

    a_pad: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid |-> o_m_axis_tdata[39:34] == 6'd0)
        else $error("padding bits set");

    a_flags: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid |-> !(o_m_axis_tdata[32] && o_m_axis_tdata[33]))
        else $error("accepted and saturated both set");

    a_add_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && o_m_axis_tdata[32] |-> o_m_axis_tdata[31:0] == 32'd0)
        else $error("add result carries a density");

    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_s_axis_tvalid && o_s_axis_tready |=> !o_s_axis_tready)
        else $error("second word taken while busy");
endmodule

bind gaussian_mixture_pixel_density gmpd_checker u_gmpd_checker (.*);
